### rtl/eoc_pkg.sv
// Package for the edge-objective correlation block.
// Holds item kind codes, the controller state type, fixed divide constants and correlation limits.
// No dependencies.
`default_nettype none
package eoc_pkg;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_EDGE   = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam int FRAC_BITS = 15;
    localparam int DIV_CNT_W = 4;

    localparam logic [15:0] CORR_ONE = 16'h8000;
    localparam logic [15:0] CORR_MAX = 16'h7fff;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE,
        ST_QRD,
        ST_QCHK,
        ST_NQ,
        ST_YY,
        ST_CNC,
        ST_D,
        ST_SQRT,
        ST_A,
        ST_B,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

### rtl/eoc_chan_if.sv
// Word channels of the edge-objective correlation block.
// Input channel carries item words, output channel carries result words.
// Depends on nothing.
`default_nettype none
interface eoc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  from_node;
    logic [5:0]  to_node;
    logic [15:0] objective;

    modport source (output valid, kind, from_node, to_node, objective, input ready);
    modport sink   (input valid, kind, from_node, to_node, objective, output ready);
endinterface

interface eoc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] correlation;
    logic        keep;
    logic        defined;

    modport source (output valid, correlation, keep, defined, input ready);
    modport sink   (input valid, correlation, keep, defined, output ready);
endinterface
`default_nettype wire

### rtl/eoc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module eoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/eoc_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, ends early on zero.
// Depends on nothing.
`default_nettype none
module eoc_mul #(
    parameter int A_W = 8,
    parameter int B_W = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [A_W-1:0]     i_a,
    input  wire logic [B_W-1:0]     i_b,
    output logic                    o_done,
    output logic [A_W+B_W-1:0]      o_prod
);
    localparam int P_W = A_W + B_W;

    logic           r_busy;
    logic [P_W-1:0] r_acc;
    logic [P_W-1:0] r_a;
    logic [B_W-1:0] r_b;

    assign o_done = r_busy && (r_b == '0);
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= P_W'(i_a);
            r_b   <= i_b;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[P_W-2:0], 1'b0};
            r_b <= r_b >> 1;
        end
    end
endmodule
`default_nettype wire

### rtl/eoc_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on nothing.
`default_nettype none
module eoc_sqrt #(
    parameter int OP_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [OP_W-1:0]   i_op,
    output logic                   o_done,
    output logic [OP_W/2-1:0]      o_root
);
    localparam int RT_W  = OP_W / 2;
    localparam int REM_W = RT_W + 2;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [OP_W-1:0]  r_op;
    logic [REM_W-1:0] r_rem;
    logic [RT_W-1:0]  r_root;
    logic [REM_W:0]   rem_sh;
    logic [REM_W:0]   trial;
    logic             ge;

    assign o_done = r_busy && (r_cnt == '0);
    assign o_root = r_root;
    assign rem_sh = {r_rem[REM_W-2:0], r_op[OP_W-1 -: 2]};
    assign trial  = (REM_W + 1)'({r_root, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= CNT_W'(RT_W);
            r_op   <= i_op;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_cnt  <= r_cnt - 1'b1;
            r_op   <= {r_op[OP_W-3:0], 2'b00};
            r_rem  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            r_root <= {r_root[RT_W-2:0], ge};
        end
    end
endmodule
`default_nettype wire

### rtl/edge_objective_correlation.sv
// Edge-objective correlation: top level with controller, sample totals and APB register.
// Depends on eoc_pkg, eoc_chan_if, eoc_ram, eoc_mul and eoc_sqrt.
//
// One item word is taken at a time. A sample word is taken in ST_IDLE; an edge word is
// read from the RAM and written back in ST_EDGE. A query takes the RAM read, six serial
// multiplications of up to max(2*CW, CW+16) bits each (CW = clog2(MAX_SAMPLES+1)) on the
// shared shift-add multiplier, a 2*CW+16-bit square root and, if the quotient is below one, a
// 15-step divide; an undefined or out-of-range query ends early. After reset all NODES*NODES
// RAM entries are swept to zero, during which no item word is taken; the threshold register
// can be written at any time.
`default_nettype none
module edge_objective_correlation
    import eoc_pkg::*;
#(
    parameter int NODES       = 64,
    parameter int MAX_SAMPLES = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    eoc_in_if.sink           i_in,
    eoc_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int DEPTH = NODES * NODES;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = CNT_W + 16;
    localparam int Q_W   = CNT_W + 32;
    localparam int V_W   = 2 * CNT_W + 32;
    localparam int CNC_W = 2 * CNT_W;
    localparam int D_W   = CNC_W + V_W;
    localparam int R_W   = D_W / 2;
    localparam int AB_W  = CNT_W + SUM_W;
    localparam int RW_W  = CNT_W + SUM_W;
    localparam int MA_W  = V_W;
    localparam int MB_W  = (CNC_W > SUM_W) ? CNC_W : SUM_W;
    localparam int P_W   = MA_W + MB_W;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_n;
    logic [SUM_W-1:0] r_y;
    logic [Q_W-1:0]   r_q;
    logic [15:0]      r_cur;
    logic [15:0]      r_thr;
    logic [IDX_W-1:0] r_clr;
    logic [IDX_W-1:0] r_idx;

    logic [CNT_W-1:0] r_c;
    logic [SUM_W-1:0] r_s;
    logic [V_W-1:0]   r_v;
    logic [R_W-1:0]   r_r;
    logic [AB_W-1:0]  r_ab;
    logic             r_neg;
    logic [R_W:0]     r_rem;
    logic [15:0]      r_k;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic [15:0]      r_res_corr;
    logic             r_res_def;

    logic             r_out_valid;
    logic [15:0]      r_out_corr;
    logic             r_out_keep;
    logic             r_out_def;

    logic             in_take;
    logic             in_range;
    logic [IDX_W-1:0] in_idx;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [RW_W-1:0]  ram_wdata;
    logic [RW_W-1:0]  ram_rdata;
    logic [CNT_W-1:0] rd_cnt;
    logic [SUM_W-1:0] rd_sum;
    logic             mul_start;
    logic [MA_W-1:0]  mul_a;
    logic [MB_W-1:0]  mul_b;
    logic             mul_done;
    logic [P_W-1:0]   mul_prod;
    logic             sq_start;
    logic             sq_done;
    logic [R_W-1:0]   sq_root;
    logic [V_W-1:0]   v_nx;
    logic [AB_W-1:0]  b_val;
    logic             b_neg;
    logic [AB_W-1:0]  b_mag;
    logic [R_W:0]     rem_sh;
    logic             div_ge;
    logic             undef_go;
    logic             out_free;
    logic             cfg_we;

    assign in_take  = i_in.valid && i_in.ready;
    assign in_range = (32'(i_in.from_node) < NODES) && (32'(i_in.to_node) < NODES);
    assign in_idx   = IDX_W'(32'(i_in.from_node) * NODES + 32'(i_in.to_node));
    assign rd_cnt   = ram_rdata[RW_W-1 -: CNT_W];
    assign rd_sum   = ram_rdata[SUM_W-1:0];
    assign v_nx     = r_v - mul_prod[V_W-1:0];
    assign b_val    = mul_prod[AB_W-1:0];
    assign b_neg    = b_val > r_ab;
    assign b_mag    = b_neg ? (b_val - r_ab) : (r_ab - b_val);
    assign rem_sh   = {r_rem[R_W-1:0], 1'b0};
    assign div_ge   = rem_sh >= {1'b0, r_r};
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.correlation = r_out_corr;
    assign o_out.keep        = r_out_keep;
    assign o_out.defined     = r_out_def;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{16{r_thr[15]}}, r_thr};

    eoc_ram #(.WIDTH(RW_W), .DEPTH(DEPTH)) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(in_idx),
        .o_rdata(ram_rdata)
    );

    eoc_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_start),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_done (mul_done),
        .o_prod (mul_prod)
    );

    eoc_sqrt #(.OP_W(D_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sq_start),
        .i_op   (mul_prod[D_W-1:0]),
        .o_done (sq_done),
        .o_root (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        sq_start  = 1'b0;
        undef_go  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == IDX_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_take) begin
                    case (i_in.kind)
                        KIND_EDGE: begin
                            if (in_range) begin
                                n_state = ST_EDGE;
                            end
                        end
                        KIND_QUERY: begin
                            n_state = in_range ? ST_QRD : ST_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EDGE: begin
                ram_wdata = {rd_cnt + 1'b1, rd_sum + SUM_W'(r_cur)};
                ram_we    = rd_cnt < CNT_W'(MAX_SAMPLES);
                n_state   = ST_IDLE;
            end
            ST_QRD: begin
                n_state = ST_QCHK;
            end
            ST_QCHK: begin
                if ((r_c == '0) || (r_c >= r_n)) begin
                    undef_go = 1'b1;
                    n_state  = ST_DONE;
                end else begin
                    mul_start = 1'b1;
                    mul_a     = MA_W'(r_q);
                    mul_b     = MB_W'(r_n);
                    n_state   = ST_NQ;
                end
            end
            ST_NQ: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = MA_W'(r_y);
                    mul_b     = MB_W'(r_y);
                    n_state   = ST_YY;
                end
            end
            ST_YY: begin
                if (mul_done) begin
                    if (v_nx == '0) begin
                        undef_go = 1'b1;
                        n_state  = ST_DONE;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = MA_W'(r_c);
                        mul_b     = MB_W'(r_n - r_c);
                        n_state   = ST_CNC;
                    end
                end
            end
            ST_CNC: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_v;
                    mul_b     = MB_W'(mul_prod[CNC_W-1:0]);
                    n_state   = ST_D;
                end
            end
            ST_D: begin
                if (mul_done) begin
                    sq_start = 1'b1;
                    n_state  = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sq_done) begin
                    if (sq_root == '0) begin
                        undef_go = 1'b1;
                        n_state  = ST_DONE;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = MA_W'(r_s);
                        mul_b     = MB_W'(r_n);
                        n_state   = ST_A;
                    end
                end
            end
            ST_A: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = MA_W'(r_y);
                    mul_b     = MB_W'(r_c);
                    n_state   = ST_B;
                end
            end
            ST_B: begin
                if (mul_done) begin
                    n_state = (b_mag >= r_r) ? ST_FIN : ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_dcnt == DIV_CNT_W'(FRAC_BITS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sample totals, sweep counter and threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_y   <= '0;
            r_q   <= '0;
            r_cur <= '0;
            r_thr <= '0;
            r_clr <= '0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (in_take && (i_in.kind == KIND_SAMPLE) && (r_n < CNT_W'(MAX_SAMPLES))) begin
                r_n   <= r_n + 1'b1;
                r_y   <= r_y + SUM_W'(i_in.objective);
                r_q   <= r_q + Q_W'(32'(i_in.objective) * 32'(i_in.objective));
                r_cur <= i_in.objective;
            end
            if (cfg_we) begin
                r_thr <= pwdata[15:0];
            end
        end
    end

    // Query datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_idx <= in_idx;
            if ((i_in.kind == KIND_QUERY) && !in_range) begin
                r_res_corr <= '0;
                r_res_def  <= 1'b0;
            end
        end
        if (undef_go) begin
            r_res_corr <= '0;
            r_res_def  <= 1'b0;
        end
        case (r_state)
            ST_QRD: begin
                r_c <= rd_cnt;
                r_s <= rd_sum;
            end
            ST_NQ: begin
                if (mul_done) begin
                    r_v <= mul_prod[V_W-1:0];
                end
            end
            ST_YY: begin
                if (mul_done) begin
                    r_v <= v_nx;
                end
            end
            ST_SQRT: begin
                if (sq_done) begin
                    r_r <= sq_root;
                end
            end
            ST_A: begin
                if (mul_done) begin
                    r_ab <= mul_prod[AB_W-1:0];
                end
            end
            ST_B: begin
                if (mul_done) begin
                    r_neg  <= b_neg;
                    r_rem  <= (R_W + 1)'(b_mag);
                    r_k    <= (b_mag >= r_r) ? CORR_ONE : '0;
                    r_dcnt <= '0;
                end
            end
            ST_DIV: begin
                r_rem  <= div_ge ? (rem_sh - {1'b0, r_r}) : rem_sh;
                r_k    <= {r_k[14:0], div_ge};
                r_dcnt <= r_dcnt + 1'b1;
            end
            ST_FIN: begin
                r_res_def <= 1'b1;
                if (r_neg) begin
                    r_res_corr <= ~r_k + 1'b1;
                end else begin
                    r_res_corr <= r_k[15] ? CORR_MAX : r_k;
                end
            end
            default: begin
            end
        endcase
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out_corr <= r_res_corr;
            r_out_def  <= r_res_def;
            r_out_keep <= $signed(r_res_corr) > $signed(r_thr);
        end
    end

    a_sample_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond limit");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_def) |-> (r_out_corr == '0))
        else $error("undefined word with non-zero correlation");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_corr)))
        else $error("stalled result word changed");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> !in_take)
        else $error("item word taken during query");

endmodule
`default_nettype wire

### verif/edge_objective_correlation_tb.sv
// Self-checking bench for edge_objective_correlation: drives sample, edge, query and spare words,
// predicts correlation/keep/defined in a behavioural model, and checks each result word.
// Depends on eoc_pkg, eoc_chan_if and the RTL of the block.
`default_nettype none
module edge_objective_correlation_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import eoc_pkg::*;

    localparam int NODES  = 64;
    localparam int MAXS   = 65536;
    localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [15:0] correlation;
        logic        keep;
        logic        defined;
    } t_corr_word;

    typedef struct {
        logic [1:0]  kind;
        logic [5:0]  from_node;
        logic [5:0]  to_node;
        logic [15:0] objective;
        bit          typed;
        t_corr_word  typed_word;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    eoc_in_if  in_ch ();
    eoc_out_if out_ch ();

    edge_objective_correlation #(.NODES(NODES), .MAX_SAMPLES(MAXS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [16:0]  pr_edge_count [NODES*NODES];
    logic [32:0]  pr_edge_sum   [NODES*NODES];
    logic [16:0]  pr_samples;
    logic [32:0]  pr_obj_total;
    logic [48:0]  pr_obj_sq_total;
    logic [15:0]  pr_current_obj;
    logic signed [15:0] pr_threshold;

    t_corr_word pending_corr[$];
    int errors = 0;
    int queries_seen = 0, undefined_seen = 0, kept_seen = 0;
    bit long_hold = 1'b0;

    function automatic logic [63:0] isqrt128(input logic [127:0] op);
        logic [127:0] res, bitv;
        res = '0;
        bitv = 128'd1 << 126;
        while (bitv != 0 && bitv > op) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (op >= res + bitv) begin
                op = op - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[63:0];
    endfunction

    function automatic t_corr_word predict_correlation(input logic [5:0] f, input logic [5:0] t);
        t_corr_word w;
        logic [127:0] n, c, s, y, v, d, a, b, mag, rem;
        logic [63:0] r;
        logic neg;
        int k;
        int idx;
        idx = f * NODES + t;
        w = '0;
        k = 0;
        n = pr_samples;
        c = pr_edge_count[idx];
        s = pr_edge_sum[idx];
        y = pr_obj_total;
        v = n * pr_obj_sq_total - y * y;
        d = c * (n - c) * v;
        r = (c == 0 || c >= n || v == 0) ? 64'd0 : isqrt128(d);
        if (r != 0) begin
            w.defined = 1'b1;
            a = n * s;
            b = c * y;
            neg = b > a;
            mag = neg ? b - a : a - b;
            if (mag >= r) begin
                k = 32768;
            end else begin
                rem = mag;
                for (int i = 0; i < 15; i++) begin
                    rem = rem << 1;
                    k = k << 1;
                    if (rem >= r) begin
                        rem = rem - r;
                        k = k | 1;
                    end
                end
            end
            if (neg) k = -k;
            else if (k > 32767) k = 32767;
        end
        w.correlation = k[15:0];
        w.keep = k > pr_threshold;
        return w;
    endfunction

    function automatic void advance_model(input logic [1:0] kind, input logic [5:0] f,
                                          input logic [5:0] t, input logic [15:0] obj);
        int idx;
        idx = f * NODES + t;
        case (kind)
            KIND_SAMPLE: begin
                if (pr_samples < MAXS) begin
                    pr_samples++;
                    pr_obj_total += obj;
                    pr_obj_sq_total += 49'(obj) * 49'(obj);
                    pr_current_obj = obj;
                end
            end
            KIND_EDGE: begin
                if (pr_edge_count[idx] < MAXS) begin
                    pr_edge_count[idx]++;
                    pr_edge_sum[idx] += pr_current_obj;
                end
            end
            KIND_QUERY: pending_corr.insert(pending_corr.size(), predict_correlation(f, t));
            default: ;
        endcase
    endfunction

    // sender: hold valid across back-to-back words, drop it only for a gap
    task automatic send_word(input logic [1:0] kind, input logic [5:0] f,
                             input logic [5:0] t, input logic [15:0] obj);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.from_node <= f;
        in_ch.to_node   <= t;
        in_ch.objective <= obj;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        advance_model(kind, f, t, obj);
    endtask

    task automatic write_threshold(input logic signed [15:0] th);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_THRESHOLD;
        pwdata <= {{16{th[15]}}, th};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        pr_threshold = th;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_corr.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // receiver
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                long_hold = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 30) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_corr.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                t_corr_word exp_w;
                exp_w = pending_corr.pop_front();
                queries_seen++;
                if (!exp_w.defined) undefined_seen++;
                if (exp_w.keep) kept_seen++;
                if (out_ch.correlation !== exp_w.correlation) begin
                    $error("correlation: expected %0d, got %0d",
                           $signed(exp_w.correlation), $signed(out_ch.correlation));
                    errors++;
                end
                if (out_ch.keep !== exp_w.keep) begin
                    $error("keep: expected %0b, got %0b", exp_w.keep, out_ch.keep);
                    errors++;
                end
                if (out_ch.defined !== exp_w.defined) begin
                    $error("defined: expected %0b, got %0b", exp_w.defined, out_ch.defined);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    t_stim_row directed[$];

    function automatic t_stim_row row(input logic [1:0] k, input logic [5:0] f,
                                      input logic [5:0] t, input logic [15:0] o,
                                      input bit typed = 0, input t_corr_word w = '0);
        t_stim_row r;
        r.kind = k; r.from_node = f; r.to_node = t; r.objective = o;
        r.typed = typed; r.typed_word = w;
        return r;
    endfunction

    function automatic void add_row(input t_stim_row r);
        directed.insert(directed.size(), r);
    endfunction

    initial begin
        t_corr_word undef_w;
        int route_len;
        int n_items;
        int it_count;
        logic [5:0] hot_f [8];
        logic [5:0] hot_t [8];
        in_ch.valid = 1'b0;
        in_ch.kind = '0;
        in_ch.from_node = '0;
        in_ch.to_node = '0;
        in_ch.objective = '0;
        foreach (pr_edge_count[i]) begin
            pr_edge_count[i] = '0;
            pr_edge_sum[i] = '0;
        end
        pr_samples = '0; pr_obj_total = '0; pr_obj_sq_total = '0;
        pr_current_obj = '0; pr_threshold = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        undef_w = '0;
        // after reset everything is undefined; then extremes and edge cases
        add_row(row(KIND_QUERY, 6'd0, 6'd0, 16'd0, 1, undef_w));
        add_row(row(KIND_QUERY, 6'd63, 6'd63, 16'hffff, 1, undef_w));
        add_row(row(KIND_EDGE, 6'd5, 6'd7, 16'd0));
        add_row(row(KIND_SPARE, 6'd5, 6'd7, 16'hffff));
        add_row(row(KIND_SAMPLE, 6'd0, 6'd0, 16'hffff));
        add_row(row(KIND_EDGE, 6'd63, 6'd0, 16'd0));
        add_row(row(KIND_EDGE, 6'd0, 6'd63, 16'd0));
        add_row(row(KIND_SAMPLE, 6'd63, 6'd63, 16'd0));
        add_row(row(KIND_EDGE, 6'd0, 6'd63, 16'd0));
        add_row(row(KIND_SAMPLE, 6'd1, 6'd2, 16'h8000));
        add_row(row(KIND_EDGE, 6'd5, 6'd7, 16'd0));
        add_row(row(KIND_QUERY, 6'd63, 6'd0, 16'd0));
        add_row(row(KIND_QUERY, 6'd0, 6'd63, 16'd0));
        add_row(row(KIND_QUERY, 6'd5, 6'd7, 16'd0));
        add_row(row(KIND_QUERY, 6'd42, 6'd21, 16'd0, 1, undef_w));
        add_row(row(KIND_SPARE, 6'd42, 6'd21, 16'h5555));

        foreach (directed[i]) begin
            if (directed[i].typed && directed[i].kind == KIND_QUERY) begin
                send_word(directed[i].kind, directed[i].from_node, directed[i].to_node,
                          directed[i].objective);
                if (pending_corr[$] !== directed[i].typed_word) begin
                    $error("directed row %0d: predicted word differs from table", i);
                    errors++;
                end
            end else begin
                send_word(directed[i].kind, directed[i].from_node, directed[i].to_node,
                          directed[i].objective);
            end
        end
        drain_results();

        n_items = 0;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_threshold(16'sh8000);
                1: write_threshold(16'sh7fff);
                2: write_threshold(16'sh0000);
                3: write_threshold(16'(signed'($urandom_range(0, 65535))));
                default: write_threshold(16'sh4000);
            endcase
            foreach (hot_f[i]) begin
                hot_f[i] = 6'($urandom_range(0, 63));
                hot_t[i] = 6'($urandom_range(0, 63));
            end
            if (phase == 2) long_hold = 1'b1;
            for (it_count = 0; it_count < 220;) begin
                // a route: sample start, edges mostly from a small hot set, then sometimes a query
                send_word(KIND_SAMPLE, 6'($urandom), 6'($urandom), 16'($urandom));
                it_count++;
                route_len = $urandom_range(1, 5);
                for (int e = 0; e < route_len; e++) begin
                    int h;
                    h = $urandom_range(0, 7);
                    if ($urandom_range(0, 9) == 0)
                        send_word(KIND_EDGE, 6'($urandom), 6'($urandom), 16'($urandom));
                    else
                        send_word(KIND_EDGE, hot_f[h], hot_t[h], 16'($urandom));
                    it_count++;
                end
                if ($urandom_range(0, 1) == 0) begin
                    int h;
                    h = $urandom_range(0, 7);
                    send_word(KIND_QUERY, hot_f[h], hot_t[h], 16'($urandom));
                    it_count++;
                end
                if ($urandom_range(0, 15) == 0) begin
                    send_word($urandom_range(0, 1) ? KIND_QUERY : KIND_SPARE,
                              6'($urandom), 6'($urandom), 16'($urandom));
                    it_count++;
                end
            end
            n_items += it_count;
            drain_results();
        end

        $display("Sent %0d random words over five threshold settings after the directed table.",
                 n_items);
        $display("Checked %0d correlation words: %0d undefined, %0d kept.",
                 queries_seen, undefined_seen, kept_seen);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
rtl/eoc_pkg.sv
rtl/eoc_chan_if.sv
rtl/eoc_ram.sv
rtl/eoc_mul.sv
rtl/eoc_sqrt.sv
rtl/edge_objective_correlation.sv
verif/edge_objective_correlation_tb.sv
